/* rtl/assert_macros.svh */
// assertion macros for the rtl files, included by the top-level file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define AST_HOLDS(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true outside reset
`define AST_NEVER(name, clk, rstn, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define AST_HOLDS(name, clk, rstn, prop, msg)
`define AST_NEVER(name, clk, rstn, expr, msg)
`endif
`endif

/* rtl/pse_pkg.sv */
// types, constants and decode helpers for the postfix stack evaluator
package pse_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int WORD_W          = 32;
    localparam int SYM_W           = 8;
    localparam int ST_W            = 2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [WORD_W-1:0] wdata;
    } stk_cmd_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic              div0;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

    function automatic op_t sym_to_op(input logic [SYM_W-1:0] sym);
        op_t op;
        case (sym)
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage

/* rtl/pse_stack.sv */
// operand stack: memory with count, registered pop data, empty pops read as zero
module pse_stack import pse_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  stk_cmd_t          cmd,
    output logic [WORD_W-1:0] rd_data,
    output logic              full
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     count_dec;
    logic [WORD_W-1:0] rd_raw_reg;
    logic              rd_zero_reg, rd_zero_next;
    logic              empty;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign count_dec = count_reg - CW'(1);
    assign rd_data   = rd_zero_reg ? '0 : rd_raw_reg;

    always_comb begin
        count_next   = count_reg;
        rd_zero_next = rd_zero_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push && !full) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            rd_zero_next = empty;
            if (!empty) begin
                count_next = count_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && !full) begin
            mem[count_reg[AW-1:0]] <= cmd.wdata;
        end
        if (cmd.pop) begin
            rd_raw_reg <= mem[count_dec[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            rd_zero_reg <= 1'b1;
        end else begin
            count_reg   <= count_next;
            rd_zero_reg <= rd_zero_next;
        end
    end

endmodule

/* rtl/pse_alu.sv */
// shared arithmetic unit: registered add/sub, 32-step shift-add multiply and restoring divide
module pse_alu import pse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output alu_rsp_t          rsp
);

    localparam int NW = $clog2(WORD_W);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX,
        A_DONE
    } alu_state_t;

    alu_state_t        state_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [NW-1:0]     cnt_reg;
    logic              neg_reg;
    logic              div0_reg;
    logic [WORD_W-1:0] res_reg;

    logic [WORD_W-1:0] a_mag, b_mag;
    logic [WORD_W:0]   rem_sh, rem_diff;
    logic              rem_ge;

    assign a_mag    = a[WORD_W-1] ? (~a + WORD_W'(1)) : a;
    assign b_mag    = b[WORD_W-1] ? (~b + WORD_W'(1)) : b;
    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh   = {acc_reg, y_reg[WORD_W-1]};
    assign rem_diff = rem_sh - {1'b0, x_reg};
    assign rem_ge   = (rem_sh >= {1'b0, x_reg});

    assign rsp = '{done: (state_reg == A_DONE), div0: div0_reg, result: res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        div0_reg <= 1'b0;
                        acc_reg  <= '0;
                        cnt_reg  <= NW'(WORD_W - 1);
                        case (req.op)
                            OP_ADD: begin
                                res_reg   <= a + b;
                                state_reg <= A_DONE;
                            end
                            OP_SUB: begin
                                res_reg   <= a - b;
                                state_reg <= A_DONE;
                            end
                            OP_MUL: begin
                                x_reg     <= a;
                                y_reg     <= b;
                                state_reg <= A_MUL;
                            end
                            default: begin
                                if (b == '0) begin
                                    res_reg   <= '0;
                                    div0_reg  <= 1'b1;
                                    state_reg <= A_DONE;
                                end else begin
                                    x_reg     <= b_mag;
                                    y_reg     <= a_mag;
                                    neg_reg   <= a[WORD_W-1] ^ b[WORD_W-1];
                                    state_reg <= A_DIV;
                                end
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    if (y_reg[0]) begin
                        acc_reg <= acc_reg + x_reg;
                    end
                    x_reg   <= {x_reg[WORD_W-2:0], 1'b0};
                    y_reg   <= {1'b0, y_reg[WORD_W-1:1]};
                    cnt_reg <= cnt_reg - NW'(1);
                    if (cnt_reg == '0) begin
                        res_reg   <= y_reg[0] ? (acc_reg + x_reg) : acc_reg;
                        state_reg <= A_DONE;
                    end
                end
                A_DIV: begin
                    acc_reg <= rem_ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
                    y_reg   <= {y_reg[WORD_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg - NW'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX: begin
                    // truncation toward zero: negate the magnitude quotient when the operand signs differ
                    res_reg   <= neg_reg ? (~y_reg + WORD_W'(1)) : y_reg;
                    state_reg <= A_DONE;
                end
                A_DONE: begin
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/postfix_stack_evaluator.sv */
// top level: character sequencer driving the operand stack and the shared arithmetic unit
//
//  channel | direction | tdata                    | tuser                               | tlast
//  --------+-----------+--------------------------+-------------------------------------+------------
//  s_      | in        | [7:0] symbol             | -                                   | end_of_expr
//  m_      | out       | [31:0] value             | [0] is_answer, [2:1] status, 0 pad  | last_of_run
//
//  digits and ignored characters are taken in the idle state; each result emitted passes an emit state
//  an operator passes two stack pops with registered read, the operand load and a wait for the shared
//  unit (add/sub direct, multiply and divide 32 iterations, divide then a sign fix), then one push
//  s_tready is high only while the sequencer is idle; one result can wait in the
//  output register while the next transaction is accepted
//  a stalled m_ side holds the sequencer in its emit state
//  reset clears the stack count, the remembered result and the output valid
module postfix_stack_evaluator import pse_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [7:0]  m_tuser,   // [0] is_answer, [2:1] status, [7:3] zero
    output logic        m_tlast
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_B,
        S_POP_A,
        S_LOAD_A,
        S_WAIT,
        S_EMIT1,
        S_EMIT2
    } seq_state_t;

    seq_state_t        state_reg;
    logic              last_reg;
    op_t               op_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] res_val_reg;
    logic [ST_W-1:0]   res_st_reg;
    logic [WORD_W-1:0] last_result_reg;
    logic              m_tvalid_reg;
    logic [WORD_W-1:0] m_tdata_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic              m_answer_reg;
    logic              m_tlast_reg;

    stk_cmd_t          stk_cmd;
    logic [WORD_W-1:0] stk_rd_data;
    logic              stk_full;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic              accept;
    logic              is_digit;
    logic              is_op;
    logic              out_free;
    logic              emit;
    logic [SYM_W-1:0]  digit_val;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign is_digit  = s_tdata inside {[CH_ZERO:CH_NINE]};
    assign is_op     = s_tdata inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = (state_reg inside {S_EMIT1, S_EMIT2}) && out_free;
    assign digit_val = s_tdata - CH_ZERO;

    always_comb begin
        stk_cmd.push  = (accept && is_digit) || (state_reg == S_WAIT && alu_rsp.done);
        stk_cmd.pop   = (state_reg == S_POP_B) || (state_reg == S_POP_A);
        stk_cmd.clear = (state_reg == S_EMIT2) && out_free;
        stk_cmd.wdata = (state_reg == S_IDLE) ? WORD_W'(digit_val) : alu_rsp.result;
    end

    assign alu_req = '{start: (state_reg == S_LOAD_A), op: op_reg};

    pse_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .rd_data (stk_rd_data),
        .full    (stk_full)
    );

    pse_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (stk_rd_data),
        .b       (b_reg),
        .rsp     (alu_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            last_result_reg <= '0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        last_reg <= s_tlast;
                        op_reg   <= sym_to_op(s_tdata);
                        if (is_digit) begin
                            if (stk_full) begin
                                res_val_reg <= '0;
                                res_st_reg  <= ST_FULL;
                                state_reg   <= S_EMIT1;
                            end else if (s_tlast) begin
                                state_reg <= S_EMIT2;
                            end
                        end else if (is_op) begin
                            state_reg <= S_POP_B;
                        end else if (s_tlast) begin
                            state_reg <= S_EMIT2;
                        end
                    end
                end
                S_POP_B: begin
                    state_reg <= S_POP_A;
                end
                S_POP_A: begin
                    b_reg     <= stk_rd_data;
                    state_reg <= S_LOAD_A;
                end
                S_LOAD_A: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        res_val_reg     <= alu_rsp.result;
                        res_st_reg      <= alu_rsp.div0 ? ST_DIV0 : ST_OK;
                        last_result_reg <= alu_rsp.result;
                        state_reg       <= S_EMIT1;
                    end
                end
                S_EMIT1: begin
                    if (out_free) begin
                        m_tdata_reg  <= res_val_reg;
                        m_status_reg <= res_st_reg;
                        m_answer_reg <= 1'b0;
                        m_tlast_reg  <= !last_reg;
                        state_reg    <= last_reg ? S_EMIT2 : S_IDLE;
                    end
                end
                S_EMIT2: begin
                    if (out_free) begin
                        m_tdata_reg     <= last_result_reg;
                        m_status_reg    <= ST_OK;
                        m_answer_reg    <= 1'b1;
                        m_tlast_reg     <= 1'b1;
                        last_result_reg <= '0;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {5'b0, m_status_reg, m_answer_reg};
    assign m_tlast  = m_tlast_reg;

    `AST_NEVER(a_push_pop_excl, aclk, aresetn, stk_cmd.push && stk_cmd.pop,
               "stack push and pop in the same cycle")
    `AST_HOLDS(a_alu_done_wait, aclk, aresetn, alu_rsp.done |-> state_reg == S_WAIT,
               "arithmetic result arrived outside the wait state")
    `AST_HOLDS(a_op_busy, aclk, aresetn, (accept && is_op) |=> !s_tready,
               "operator transaction did not hold off the input")
    `AST_HOLDS(a_answer_form, aclk, aresetn,
               (m_tvalid_reg && m_answer_reg) |-> (m_tlast_reg && m_status_reg == ST_OK),
               "answer result without last flag or with nonzero status")

endmodule
